// ===== rtl/core/cbdu_pkg.sv =====
// ----------------------------------------------------------------------------
// CPU breakpoint debug unit package
// Shared sizes, request, mode and status codes, and the controller command
// bundle.
// ----------------------------------------------------------------------------
package cbdu_pkg;

    localparam int BP_ENTRIES = 16;
    localparam int IDX_W      = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(BP_ENTRIES + 1);

    localparam logic [3:0] REQ_FETCH    = 4'd0;
    localparam logic [3:0] REQ_STEP     = 4'd1;
    localparam logic [3:0] REQ_NEXT     = 4'd2;
    localparam logic [3:0] REQ_CONTINUE = 4'd3;
    localparam logic [3:0] REQ_STOP     = 4'd4;
    localparam logic [3:0] REQ_EXIT     = 4'd5;
    localparam logic [3:0] REQ_TOGGLE   = 4'd6;
    localparam logic [3:0] REQ_ENABLE   = 4'd7;
    localparam logic [3:0] REQ_DISABLE  = 4'd8;
    localparam logic [3:0] REQ_DELETE   = 4'd9;

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_CONTINUE  = 3'd1;
    localparam logic [2:0] MODE_STEP_OVER = 3'd2;
    localparam logic [2:0] MODE_WAITING   = 3'd3;
    localparam logic [2:0] MODE_SINGLE    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
    } cbdu_cmd_t;

endpackage

// ===== rtl/core/cbdu_ctrl.sv =====
// ----------------------------------------------------------------------------
// CPU breakpoint debug unit controller
// Two-state sequencer: captures a request, then runs the execute state and
// raises the result strobe after it.
// ----------------------------------------------------------------------------
module cbdu_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output cbdu_pkg::cbdu_cmd_t cmd
);
    import cbdu_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign busy        = (state_reg == S_EXEC);
    assign done        = done_reg;
    assign cmd.capture = start && (state_reg == S_IDLE);
    assign cmd.exec    = (state_reg == S_EXEC);

    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done)
        else $error("Execute cycle was not followed by a result strobe.");

    a_done_needs_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.exec))
        else $error("Result strobe without a preceding execute cycle.");

endmodule

// ===== rtl/core/cbdu_dp.sv =====
// ----------------------------------------------------------------------------
// CPU breakpoint debug unit datapath
// Request capture, compacted breakpoint table with parallel match, debug
// mode, active-breakpoint mark and result registers.
// ----------------------------------------------------------------------------
module cbdu_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  cbdu_pkg::cbdu_cmd_t cmd,
    input  logic [3:0]          req_type,
    input  logic [15:0]         pc,
    input  logic                is_call,
    input  logic [1:0]          instr_size,
    input  logic [15:0]         break_addr,
    input  logic [7:0]          entry_index,
    output logic                run,
    output logic                hit,
    output logic                hit_user,
    output logic [15:0]         hit_address,
    output logic [1:0]          status,
    output logic [2:0]          mode,
    output logic [4:0]          entry_count
);
    import cbdu_pkg::*;

    logic [3:0]  rq_type_reg;
    logic [15:0] rq_pc_reg;
    logic        rq_call_reg;
    logic [1:0]  rq_size_reg;
    logic [15:0] rq_baddr_reg;
    logic [7:0]  rq_index_reg;

    logic [15:0]           addr_reg [BP_ENTRIES];
    logic [15:0]           addr_next [BP_ENTRIES];
    logic [BP_ENTRIES-1:0] temp_reg;
    logic [BP_ENTRIES-1:0] temp_next;
    logic [BP_ENTRIES-1:0] en_reg;
    logic [BP_ENTRIES-1:0] en_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [2:0]            mode_reg;
    logic [2:0]            mode_next;
    logic                  act_valid_reg;
    logic                  act_valid_next;
    logic [IDX_W-1:0]      act_index_reg;
    logic [IDX_W-1:0]      act_index_next;

    logic        run_reg;
    logic        run_next;
    logic        hit_reg;
    logic        hit_next;
    logic        hit_user_reg;
    logic        hit_user_next;
    logic [15:0] hit_addr_reg;
    logic [15:0] hit_addr_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;

    logic             fh_found;
    logic [IDX_W-1:0] fh_idx;
    logic             tg_found;
    logic [IDX_W-1:0] tg_idx;

    always_comb
    begin
        fh_found = 1'b0;
        fh_idx   = '0;
        tg_found = 1'b0;
        tg_idx   = '0;
        for (int i = BP_ENTRIES - 1; i >= 0; i--)
        begin
            if ((CNT_W'(i) < count_reg) && en_reg[i] && (addr_reg[i] == rq_pc_reg) &&
                !(act_valid_reg && (act_index_reg == IDX_W'(i))))
            begin
                fh_found = 1'b1;
                fh_idx   = IDX_W'(i);
            end
            if ((CNT_W'(i) < count_reg) && !temp_reg[i] && (addr_reg[i] == rq_baddr_reg))
            begin
                tg_found = 1'b1;
                tg_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        logic             rm_en;
        logic [IDX_W-1:0] rm_k;
        logic             ap_en;
        logic [15:0]      ap_addr;
        logic             ap_temp;
        logic             full;
        logic             bad_idx;
        logic [IDX_W-1:0] sel;

        rm_en   = 1'b0;
        rm_k    = '0;
        ap_en   = 1'b0;
        ap_addr = '0;
        ap_temp = 1'b0;
        full    = (count_reg == CNT_W'(BP_ENTRIES));
        bad_idx = (32'(rq_index_reg) >= 32'(count_reg));
        sel     = rq_index_reg[IDX_W-1:0];

        addr_next      = addr_reg;
        temp_next      = temp_reg;
        en_next        = en_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        act_valid_next = act_valid_reg;
        act_index_next = act_index_reg;
        run_next       = 1'b0;
        hit_next       = 1'b0;
        hit_user_next  = 1'b0;
        hit_addr_next  = '0;
        status_next    = ST_OK;

        case (rq_type_reg)
            REQ_FETCH:
            begin
                if ((mode_reg == MODE_IDLE) || (mode_reg == MODE_CONTINUE) ||
                    (mode_reg == MODE_STEP_OVER))
                begin
                    if (fh_found)
                    begin
                        hit_next       = 1'b1;
                        hit_user_next  = !temp_reg[fh_idx];
                        hit_addr_next  = addr_reg[fh_idx];
                        mode_next      = MODE_WAITING;
                        act_valid_next = 1'b1;
                        act_index_next = fh_idx;
                        if (temp_reg[fh_idx])
                        begin
                            rm_en = 1'b1;
                            rm_k  = fh_idx;
                        end
                    end
                    else
                    begin
                        run_next = 1'b1;
                        if ((mode_reg != MODE_IDLE) && act_valid_reg)
                        begin
                            act_valid_next = 1'b0;
                            act_index_next = '0;
                        end
                    end
                end
                else if (mode_reg == MODE_SINGLE)
                begin
                    run_next  = 1'b1;
                    mode_next = MODE_WAITING;
                end
            end
            REQ_STEP, REQ_STOP:
            begin
                mode_next = MODE_SINGLE;
            end
            REQ_NEXT:
            begin
                if (rq_call_reg && !full)
                begin
                    ap_en     = 1'b1;
                    ap_addr   = rq_pc_reg + {14'd0, rq_size_reg};
                    ap_temp   = 1'b1;
                    mode_next = MODE_STEP_OVER;
                end
                else
                begin
                    if (rq_call_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    mode_next = MODE_SINGLE;
                end
            end
            REQ_CONTINUE:
            begin
                mode_next = MODE_CONTINUE;
            end
            REQ_EXIT:
            begin
                mode_next = MODE_IDLE;
            end
            REQ_TOGGLE:
            begin
                if (tg_found)
                begin
                    rm_en = 1'b1;
                    rm_k  = tg_idx;
                end
                else if (!full)
                begin
                    ap_en   = 1'b1;
                    ap_addr = rq_baddr_reg;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            REQ_ENABLE, REQ_DISABLE, REQ_DELETE:
            begin
                if (bad_idx)
                begin
                    status_next = ST_BAD_INDEX;
                end
                else if (rq_type_reg == REQ_ENABLE)
                begin
                    en_next[sel] = 1'b1;
                end
                else if (rq_type_reg == REQ_DISABLE)
                begin
                    en_next[sel] = 1'b0;
                end
                else
                begin
                    rm_en = 1'b1;
                    rm_k  = sel;
                end
            end
            default:
            begin
            end
        endcase

        if (rm_en)
        begin
            for (int j = 0; j < BP_ENTRIES - 1; j++)
            begin
                if (CNT_W'(j) >= CNT_W'(rm_k))
                begin
                    addr_next[j] = addr_reg[j + 1];
                    temp_next[j] = temp_reg[j + 1];
                    en_next[j]   = en_reg[j + 1];
                end
            end
            count_next = count_reg - CNT_W'(1);
            if (act_valid_next)
            begin
                if (act_index_next == rm_k)
                begin
                    act_valid_next = 1'b0;
                    act_index_next = '0;
                end
                else if (act_index_next > rm_k)
                begin
                    act_index_next = act_index_next - IDX_W'(1);
                end
            end
        end

        if (ap_en)
        begin
            addr_next[count_reg[IDX_W-1:0]] = ap_addr;
            temp_next[count_reg[IDX_W-1:0]] = ap_temp;
            en_next[count_reg[IDX_W-1:0]]   = 1'b1;
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rq_type_reg  <= req_type;
            rq_pc_reg    <= pc;
            rq_call_reg  <= is_call;
            rq_size_reg  <= instr_size;
            rq_baddr_reg <= break_addr;
            rq_index_reg <= entry_index;
        end
        if (cmd.exec)
        begin
            addr_reg     <= addr_next;
            temp_reg     <= temp_next;
            en_reg       <= en_next;
            run_reg      <= run_next;
            hit_reg      <= hit_next;
            hit_user_reg <= hit_user_next;
            hit_addr_reg <= hit_addr_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mode_reg      <= MODE_IDLE;
            act_valid_reg <= 1'b0;
            act_index_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            act_valid_reg <= act_valid_next;
            act_index_reg <= act_index_next;
        end
    end

    assign run         = run_reg;
    assign hit         = hit_reg;
    assign hit_user    = hit_user_reg;
    assign hit_address = hit_addr_reg;
    assign status      = status_reg;
    assign mode        = mode_reg;
    assign entry_count = 5'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BP_ENTRIES))
        else $error("Breakpoint count exceeds the table size.");

    a_mark_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> (CNT_W'(act_index_reg) < count_reg))
        else $error("Active mark points outside the held entries.");

endmodule

// ===== rtl/core/cpu_breakpoint_debug_unit_core.sv =====
// ----------------------------------------------------------------------------
// CPU breakpoint debug unit core
// A request is captured in the idle state and executed in the execute state,
// and the result strobe is registered from the execute state.
// A new request is taken only once the execute state has ended; busy is high meanwhile.
// The table match and compaction finish within the execute state.
// Reset clears mode, entry count and active mark; results cannot be stalled.
// ----------------------------------------------------------------------------
module cpu_breakpoint_debug_unit_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  req_type,
    input  logic [15:0] pc,
    input  logic        is_call,
    input  logic [1:0]  instr_size,
    input  logic [15:0] break_addr,
    input  logic [7:0]  entry_index,
    output logic        done,
    output logic        run,
    output logic        hit,
    output logic        hit_user,
    output logic [15:0] hit_address,
    output logic [1:0]  status,
    output logic [2:0]  mode,
    output logic [4:0]  entry_count
);
    import cbdu_pkg::*;

    cbdu_cmd_t cmd;

    cbdu_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    cbdu_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .pc          (pc),
        .is_call     (is_call),
        .instr_size  (instr_size),
        .break_addr  (break_addr),
        .entry_index (entry_index),
        .run         (run),
        .hit         (hit),
        .hit_user    (hit_user),
        .hit_address (hit_address),
        .status      (status),
        .mode        (mode),
        .entry_count (entry_count)
    );

endmodule

// ===== verif/tb_cpu_breakpoint_debug_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the CPU breakpoint debug unit core
// Drives fetch and debugger command requests through the start/busy handshake
// in bursts with random gaps, mirrors the mode, breakpoint table and active
// mark in a shadow copy, and compares every result strobe field by field.
// ----------------------------------------------------------------------------
import cbdu_pkg::*;

typedef struct {
    logic [3:0]  req_type;
    logic [15:0] pc;
    logic        is_call;
    logic [1:0]  instr_size;
    logic [15:0] break_addr;
    logic [7:0]  entry_index;
} bp_request_t;

typedef struct {
    logic        run;
    logic        hit;
    logic        hit_user;
    logic [15:0] hit_address;
    logic [1:0]  status;
    logic [2:0]  mode;
    logic [4:0]  entry_count;
} bp_outcome_t;

class breakpoint_shadow;
    logic [2:0]  dbg_mode;
    logic [15:0] entry_addr [BP_ENTRIES];
    bit          entry_temp [BP_ENTRIES];
    bit          entry_en   [BP_ENTRIES];
    int          entry_total;
    bit          act_valid;
    int          act_idx;
    bp_outcome_t pending_outcomes [$];
    int          errors;
    int          n_results;
    int          n_hits;
    int          n_full;
    int          n_bad_index;

    function new();
        dbg_mode    = MODE_IDLE;
        entry_total = 0;
        act_valid   = 1'b0;
        act_idx     = 0;
        errors      = 0;
        n_results   = 0;
        n_hits      = 0;
        n_full      = 0;
        n_bad_index = 0;
        for (int i = 0; i < BP_ENTRIES; i++)
        begin
            entry_addr[i] = '0;
            entry_temp[i] = 1'b0;
            entry_en[i]   = 1'b0;
        end
    endfunction

    function void drop_entry(int k);
        if (k >= entry_total)
            return;
        for (int j = k; j + 1 < entry_total; j++)
        begin
            entry_addr[j] = entry_addr[j + 1];
            entry_temp[j] = entry_temp[j + 1];
            entry_en[j]   = entry_en[j + 1];
        end
        entry_total--;
        if (act_valid)
        begin
            if (act_idx == k)
            begin
                act_valid = 1'b0;
                act_idx   = 0;
            end
            else if (act_idx > k)
            begin
                act_idx--;
            end
        end
    endfunction

    function bit add_entry(logic [15:0] a, bit t);
        if (entry_total >= BP_ENTRIES)
            return 1'b0;
        entry_addr[entry_total] = a;
        entry_temp[entry_total] = t;
        entry_en[entry_total]   = 1'b1;
        entry_total++;
        return 1'b1;
    endfunction

    function void apply_request(bp_request_t rq);
        bp_outcome_t o;
        bit          found;
        o.run         = 1'b0;
        o.hit         = 1'b0;
        o.hit_user    = 1'b0;
        o.hit_address = '0;
        o.status      = ST_OK;
        found         = 1'b0;
        case (rq.req_type)
            REQ_FETCH:
            begin
                o.run = 1'b1;
                if (dbg_mode == MODE_IDLE || dbg_mode == MODE_CONTINUE ||
                    dbg_mode == MODE_STEP_OVER)
                begin
                    for (int i = 0; i < entry_total; i++)
                    begin
                        if (!found && entry_en[i] && !(act_valid && act_idx == i) &&
                            entry_addr[i] == rq.pc)
                        begin
                            found         = 1'b1;
                            o.run         = 1'b0;
                            o.hit         = 1'b1;
                            o.hit_user    = !entry_temp[i];
                            o.hit_address = entry_addr[i];
                            dbg_mode      = MODE_WAITING;
                            act_valid     = 1'b1;
                            act_idx       = i;
                            n_hits++;
                            if (entry_temp[i])
                                drop_entry(i);
                        end
                    end
                end
                else if (dbg_mode == MODE_WAITING)
                begin
                    o.run = 1'b0;
                end
                else if (dbg_mode == MODE_SINGLE)
                begin
                    dbg_mode = MODE_WAITING;
                end
                if ((dbg_mode == MODE_STEP_OVER || dbg_mode == MODE_CONTINUE) && act_valid)
                begin
                    act_valid = 1'b0;
                    act_idx   = 0;
                    o.run     = 1'b1;
                end
            end
            REQ_STEP, REQ_STOP:
            begin
                dbg_mode = MODE_SINGLE;
            end
            REQ_NEXT:
            begin
                if (rq.is_call)
                begin
                    if (add_entry(16'(rq.pc + 16'(rq.instr_size)), 1'b1))
                    begin
                        dbg_mode = MODE_STEP_OVER;
                    end
                    else
                    begin
                        o.status = ST_FULL;
                        dbg_mode = MODE_SINGLE;
                    end
                end
                else
                begin
                    dbg_mode = MODE_SINGLE;
                end
            end
            REQ_CONTINUE:
            begin
                dbg_mode = MODE_CONTINUE;
            end
            REQ_EXIT:
            begin
                dbg_mode = MODE_IDLE;
            end
            REQ_TOGGLE:
            begin
                for (int i = 0; i < entry_total; i++)
                begin
                    if (!found && !entry_temp[i] && entry_addr[i] == rq.break_addr)
                    begin
                        drop_entry(i);
                        found = 1'b1;
                    end
                end
                if (!found && !add_entry(rq.break_addr, 1'b0))
                    o.status = ST_FULL;
            end
            REQ_ENABLE, REQ_DISABLE, REQ_DELETE:
            begin
                if (int'(rq.entry_index) >= entry_total)
                begin
                    o.status = ST_BAD_INDEX;
                end
                else if (rq.req_type == REQ_ENABLE)
                begin
                    entry_en[rq.entry_index] = 1'b1;
                end
                else if (rq.req_type == REQ_DISABLE)
                begin
                    entry_en[rq.entry_index] = 1'b0;
                end
                else
                begin
                    drop_entry(int'(rq.entry_index));
                end
            end
            default:
            begin
            end
        endcase
        if (o.status == ST_FULL)
            n_full++;
        if (o.status == ST_BAD_INDEX)
            n_bad_index++;
        o.mode        = dbg_mode;
        o.entry_count = 5'(entry_total);
        pending_outcomes = {pending_outcomes, o};
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
        $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
    endfunction

    function void compare_outcome(bp_outcome_t got);
        bp_outcome_t want;
        if (pending_outcomes.size() == 0)
        begin
            $display("[%0t] result strobe with no transfer outstanding", $time);
            errors++;
            return;
        end
        want = pending_outcomes.pop_front();
        n_results++;
        if (got.run !== want.run)
            report("run", 16'(want.run), 16'(got.run));
        if (got.hit !== want.hit)
            report("hit", 16'(want.hit), 16'(got.hit));
        if (got.hit_user !== want.hit_user)
            report("hit_user", 16'(want.hit_user), 16'(got.hit_user));
        if (got.hit_address !== want.hit_address)
            report("hit_address", want.hit_address, got.hit_address);
        if (got.status !== want.status)
            report("status", 16'(want.status), 16'(got.status));
        if (got.mode !== want.mode)
            report("mode", 16'(want.mode), 16'(got.mode));
        if (got.entry_count !== want.entry_count)
            report("entry_count", 16'(want.entry_count), 16'(got.entry_count));
    endfunction
endclass

module tb_cpu_breakpoint_debug_unit_core;

    localparam logic [3:0] REQ_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;
    localparam int         RANDOM_ITEMS     = 1750;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  req_type;
    logic [15:0] pc;
    logic        is_call;
    logic [1:0]  instr_size;
    logic [15:0] break_addr;
    logic [7:0]  entry_index;
    logic        done;
    logic        run;
    logic        hit;
    logic        hit_user;
    logic [15:0] hit_address;
    logic [1:0]  status;
    logic [2:0]  mode;
    logic [4:0]  entry_count;

    breakpoint_shadow shadow;
    int               burst_left;
    logic [15:0]      addr_pool [0:11] = '{16'h0000, 16'hFFFF, 16'h1000, 16'h1001,
                                           16'h1002, 16'h1003, 16'h8000, 16'h7FFF,
                                           16'h0100, 16'h0103, 16'h2222, 16'hFFFE};

    cpu_breakpoint_debug_unit_core DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .pc          (pc),
        .is_call     (is_call),
        .instr_size  (instr_size),
        .break_addr  (break_addr),
        .entry_index (entry_index),
        .done        (done),
        .run         (run),
        .hit         (hit),
        .hit_user    (hit_user),
        .hit_address (hit_address),
        .status      (status),
        .mode        (mode),
        .entry_count (entry_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        bp_outcome_t got;
        if (rst_n && done)
        begin
            got.run         = run;
            got.hit         = hit;
            got.hit_user    = hit_user;
            got.hit_address = hit_address;
            got.status      = status;
            got.mode        = mode;
            got.entry_count = entry_count;
            shadow.compare_outcome(got);
        end
    end

    function automatic bp_request_t mk(logic [3:0] kind, logic [15:0] p, logic c,
                                       logic [1:0] sz, logic [15:0] ba, logic [7:0] ix);
        bp_request_t rq;
        rq.req_type    = kind;
        rq.pc          = p;
        rq.is_call     = c;
        rq.instr_size  = sz;
        rq.break_addr  = ba;
        rq.entry_index = ix;
        return rq;
    endfunction

    function automatic bp_request_t random_request();
        bp_request_t rq;
        int          r;
        int          cnt;
        rq.req_type    = REQ_FETCH;
        rq.pc          = 16'($urandom);
        rq.is_call     = 1'($urandom_range(0, 1));
        rq.instr_size  = 2'($urandom_range(1, 3));
        rq.break_addr  = 16'($urandom);
        rq.entry_index = 8'($urandom);
        cnt            = shadow.entry_total;
        r              = int'($urandom_range(0, 99));
        if (r < 36)
        begin
            if (cnt > 0 && $urandom_range(0, 9) < 6)
                rq.pc = shadow.entry_addr[$urandom_range(0, cnt - 1)];
            else if ($urandom_range(0, 1) == 1)
                rq.pc = addr_pool[$urandom_range(0, 11)];
        end
        else if (r < 50)
        begin
            rq.req_type = REQ_TOGGLE;
            if ($urandom_range(0, 4) != 0)
                rq.break_addr = addr_pool[$urandom_range(0, 11)];
        end
        else if (r < 58)
        begin
            rq.req_type = REQ_NEXT;
            rq.is_call  = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 2) != 0)
                rq.pc = addr_pool[$urandom_range(0, 11)];
        end
        else if (r < 66)
        begin
            rq.req_type = REQ_CONTINUE;
        end
        else if (r < 70)
        begin
            rq.req_type = REQ_STEP;
        end
        else if (r < 73)
        begin
            rq.req_type = REQ_STOP;
        end
        else if (r < 75)
        begin
            rq.req_type = REQ_EXIT;
        end
        else if (r < 92)
        begin
            rq.req_type = (r < 80) ? REQ_ENABLE : ((r < 85) ? REQ_DISABLE : REQ_DELETE);
            if ($urandom_range(0, 6) != 0)
                rq.entry_index = 8'($urandom_range(0, cnt));
        end
        else
        begin
            rq.req_type = 4'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        end
        return rq;
    endfunction

    task automatic transfer_request(input bp_request_t rq);
        int gap;
        @(negedge clk);
        start       <= 1'b1;
        req_type    <= rq.req_type;
        pc          <= rq.pc;
        is_call     <= rq.is_call;
        instr_size  <= rq.instr_size;
        break_addr  <= rq.break_addr;
        entry_index <= rq.entry_index;
        do
            @(posedge clk);
        while (busy);
        shadow.apply_request(rq);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = int'($urandom_range(1, 6));
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : int'($urandom_range(1, 20));
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("tb_cpu_breakpoint_debug_unit_core: done, errors");
        $finish;
    end

    initial
    begin
        bp_request_t directed [$];
        int          guard;
        int          waited;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_FETCH;
        pc          = '0;
        is_call     = 1'b0;
        instr_size  = 2'd1;
        break_addr  = '0;
        entry_index = '0;
        burst_left  = 5;
        shadow      = new();

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        directed = {directed, mk(REQ_FETCH,    16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_TOGGLE,   16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_TOGGLE,   16'h0000, 1'b0, 2'd1, 16'hFFFF, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'hFFFF, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'hFFFF, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_CONTINUE, 16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'hFFFF, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_NEXT,     16'hFFFE, 1'b1, 2'd3, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'h0001, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_NEXT,     16'h0010, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'h1234, 1'b0, 2'd2, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_STEP,     16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_STOP,     16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_DISABLE,  16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_CONTINUE, 16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_ENABLE,   16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_FETCH,    16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_DELETE,   16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_DELETE,   16'h0000, 1'b0, 2'd1, 16'h0000, 8'd255)};
        directed = {directed, mk(REQ_ENABLE,   16'h0000, 1'b0, 2'd1, 16'h0000, 8'd1)};
        directed = {directed, mk(REQ_TOGGLE,   16'h0000, 1'b0, 2'd1, 16'hFFFF, 8'd0)};
        directed = {directed, mk(REQ_EXIT,     16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0)};
        directed = {directed, mk(REQ_UNUSED_LAST, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF, 8'd255)};
        directed = {directed, mk(REQ_NEXT,     16'h1000, 1'b1, 2'd1, 16'h0000, 8'd0)};
        foreach (directed[i])
            transfer_request(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 350 == 175)
            begin
                guard = 0;
                while (shadow.entry_total < BP_ENTRIES && guard < 64)
                begin
                    transfer_request(mk(REQ_TOGGLE, 16'h0000, 1'b0, 2'd1,
                                        16'($urandom), 8'd0));
                    guard++;
                end
                transfer_request(mk(REQ_TOGGLE, 16'h0000, 1'b0, 2'd1, 16'($urandom), 8'd0));
                transfer_request(mk(REQ_NEXT, 16'($urandom), 1'b1, 2'($urandom_range(1, 3)),
                                    16'h0000, 8'd0));
                transfer_request(mk(REQ_CONTINUE, 16'h0000, 1'b0, 2'd1, 16'h0000, 8'd0));
            end
            transfer_request(random_request());
        end

        @(negedge clk);
        start <= 1'b0;

        waited = 0;
        while (shadow.pending_outcomes.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        if (shadow.pending_outcomes.size() != 0)
        begin
            $display("[%0t] %0d results never arrived", $time,
                     shadow.pending_outcomes.size());
            $display("tb_cpu_breakpoint_debug_unit_core: done, errors");
            $finish;
        end
        else
        begin
            repeat (10) @(posedge clk);
            $display("Checked %0d transfers with %0d breakpoint stops.",
                     shadow.n_results, shadow.n_hits);
            $display("Saw %0d table-full and %0d bad-index reports.",
                     shadow.n_full, shadow.n_bad_index);
            if (shadow.errors == 0)
                $display("tb_cpu_breakpoint_debug_unit_core: done, clean");
            else
                $display("tb_cpu_breakpoint_debug_unit_core: done, errors");
            $finish;
        end
    end

endmodule
